// ----- rtl/rtu_pkg.sv -----
// Package: constants, types and codes shared by the route table update block.
package rtu_pkg;

   localparam int ENTRIES = 32;
   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int SLOT_OUT_W = 5;

   // Packed table entry: dest, mac, port, hops, last bcast, flag, rsrc, rdst
   localparam int ENTRY_W = 32 + 48 + 8 + 8 + 32 + 1 + 32 + 32;

   localparam logic [1:0] KIND_RREQ = 2'd0;
   localparam logic [1:0] KIND_RREP = 2'd1;

   localparam logic [1:0] ST_DUP = 2'd0;
   localparam logic [1:0] ST_UPDATED = 2'd1;
   localparam logic [1:0] ST_SELF = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [31:0] dest;
      logic [47:0] next_mac;
      logic [7:0] port;
      logic [7:0] hops;
      logic [31:0] last_bcast;
      logic flag;
      logic [31:0] rsrc;
      logic [31:0] rdst;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_READ,
      S_DECIDE,
      S_RESULT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture input word
      logic scan_start; // clear scan index, issue read of slot 0
      logic scan_next;  // advance scan index, issue read
      logic read_hit;   // issue read of hit slot
      logic decide;     // compute outcome and write table
      logic rsp_load;   // load result register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_self;
      logic scan_done; // entry count is zero (table empty)
      logic match;     // registered read data matches source
      logic scan_last; // current index is last valid one
   } stat_type;

endpackage

// ----- rtl/rtu_ram.sv -----
// Generic single-port RAM with registered read.
module rtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rtu_ctrl.sv -----
// Controller state machine: sequences the table scan and the update.
module rtu_ctrl import rtu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     rsp_busy,
   input  stat_type stat,
   output logic     req_ready,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.is_self || stat.scan_done) state_in = S_DECIDE;
            else state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.match) state_in = S_READ;
            else if (stat.scan_last) state_in = S_DECIDE;
            else state_in = S_CHECK;
         end
         S_READ: state_in = S_DECIDE;
         S_DECIDE: state_in = S_RESULT;
         S_RESULT: begin
            if (!rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_fire;
         end
         S_SCAN: cmd.scan_start = 1'b1;
         S_CHECK: begin
            if (stat.match) cmd.read_hit = 1'b1;
            else if (!stat.scan_last) cmd.scan_next = 1'b1;
         end
         S_READ: ;
         S_DECIDE: cmd.decide = 1'b1;
         S_RESULT: cmd.rsp_load = !rsp_busy;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_SCAN)
      else $error("accepted word did not start a scan");
   assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> state_ff == S_RESULT)
      else $error("decide not followed by result");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("ready while busy");
`endif

endmodule

// ----- rtl/rtu_dp.sv -----
// Datapath: input capture, own address, entry count, table RAM and decision.
module rtu_dp import rtu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  csr_fire,
   input  logic [31:0]           csr_own_addr,
   input  logic [1:0]            in_kind,
   input  logic [31:0]           in_src,
   input  logic [31:0]           in_dst,
   input  logic [31:0]           in_bid,
   input  logic [7:0]            in_hops,
   input  logic                  in_force,
   input  logic [47:0]           in_mac,
   input  logic [7:0]            in_port,
   output stat_type              stat,
   output logic [1:0]            res_status,
   output logic [SLOT_OUT_W-1:0] res_slot
);

   logic [31:0] own_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [1:0] kind_ff;
   logic [31:0] src_ff, dst_ff, bid_ff;
   logic [7:0] hops_ff, port_ff;
   logic force_ff;
   logic [47:0] mac_ff;
   logic found_ff;
   logic [SLOT_W-1:0] hit_ff;
   logic [1:0] status_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;

   logic [SLOT_W-1:0] ram_addr;
   logic ram_we;
   entry_type ram_wdata, ram_rdata, new_ent;
   logic is_req, is_rep;
   logic [1:0] status_in;
   logic [SLOT_W-1:0] slot_in;

   assign is_req = kind_ff == KIND_RREQ;
   assign is_rep = kind_ff == KIND_RREP;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_fire) own_ff <= csr_own_addr;
         if (ram_we && !found_ff) count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind;
         src_ff <= in_src;
         dst_ff <= in_dst;
         bid_ff <= in_bid;
         hops_ff <= (in_hops == 8'hFF) ? 8'hFF : in_hops + 8'd1;
         force_ff <= in_force;
         mac_ff <= in_mac;
         port_ff <= in_port;
         found_ff <= 1'b0;
      end
      if (cmd.scan_start) idx_ff <= '0;
      if (cmd.scan_next) idx_ff <= idx_ff + 1'b1;
      if (cmd.read_hit) begin
         found_ff <= 1'b1;
         hit_ff <= idx_ff[SLOT_W-1:0];
      end
      if (cmd.decide) begin
         status_ff <= status_in;
         slot_ff <= SLOT_OUT_W'(slot_in);
      end
   end

   assign stat.is_self = src_ff == own_ff;
   assign stat.scan_done = count_ff == '0;
   assign stat.match = ram_rdata.dest == src_ff;
   assign stat.scan_last = idx_ff + 1'b1 >= count_ff;

   // Fresh entry for a new originator or a forced rediscovery.
   always_comb begin
      new_ent.dest = src_ff;
      new_ent.next_mac = mac_ff;
      new_ent.port = port_ff;
      new_ent.hops = hops_ff;
      new_ent.last_bcast = is_req ? bid_ff : 32'd0;
      new_ent.flag = is_req && force_ff;
      new_ent.rsrc = (is_req && force_ff) ? src_ff : 32'd0;
      new_ent.rdst = (is_req && force_ff) ? dst_ff : 32'd0;
   end

   always_comb begin
      ram_we = 1'b0;
      ram_wdata = ram_rdata;
      status_in = ST_DUP;
      slot_in = hit_ff;
      if (stat.is_self) begin
         status_in = ST_SELF;
         slot_in = '0;
      end else if (!found_ff) begin
         if (count_ff >= CNT_W'(ENTRIES)) begin
            status_in = ST_FULL;
            slot_in = '0;
         end else begin
            status_in = ST_UPDATED;
            slot_in = count_ff[SLOT_W-1:0];
            ram_wdata = new_ent;
            ram_we = cmd.decide;
         end
      end else if (force_ff && !ram_rdata.flag) begin
         status_in = ST_UPDATED;
         ram_wdata = new_ent;
         ram_we = cmd.decide;
      end else begin
         if (is_rep && ram_rdata.flag && ram_rdata.rdst == src_ff
             && ram_rdata.rsrc == dst_ff) begin
            ram_wdata.flag = 1'b0;
            ram_wdata.rsrc = '0;
            ram_wdata.rdst = '0;
         end
         if (ram_rdata.last_bcast == bid_ff) begin
            if (hops_ff < ram_rdata.hops) begin
               status_in = ST_UPDATED;
               ram_wdata.next_mac = mac_ff;
               ram_wdata.port = port_ff;
               ram_wdata.hops = hops_ff;
            end
         end else if (bid_ff > ram_rdata.last_bcast) begin
            status_in = ST_UPDATED;
            if (hops_ff < ram_rdata.hops) begin
               ram_wdata.next_mac = mac_ff;
               ram_wdata.port = port_ff;
               ram_wdata.hops = hops_ff;
            end
            if (is_req) ram_wdata.last_bcast = bid_ff;
         end
         ram_we = cmd.decide;
      end
   end

   always_comb begin
      ram_addr = idx_ff[SLOT_W-1:0];
      if (cmd.scan_start) ram_addr = '0;
      else if (cmd.scan_next) ram_addr = idx_ff[SLOT_W-1:0] + 1'b1;
      else if (cmd.decide) ram_addr = slot_in;
   end

   rtu_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign res_status = status_ff;
   assign res_slot = slot_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count overflow");
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> cmd.decide && !stat.is_self)
      else $error("table write outside decide");
   assert property (@(posedge clock) disable iff (reset)
      cmd.decide && status_in == ST_FULL |-> !ram_we)
      else $error("write on full table");
`endif

endmodule

// ----- rtl/route_table_update_on_control_packet.sv -----
// Top level: route table update on received route control packets.
// Sequence: scan the table one entry per cycle (one read port), read the hit slot on a match,
// decide and write the table, then load the result; self origin and empty table skip the scan.
// One word at a time: next word taken the cycle after the result loads.
// Reset (synchronous, active high) clears own address and entry count; table RAM not cleared.
module route_table_update_on_control_packet import rtu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data,      // own_addr
   input  logic         req_tvalid,
   output logic         req_tready,
   // pkt_kind[1:0], source_addr[33:2], dest_addr[65:34], bcast_id[97:66],
   // hops_in[105:98], force_rediscover[106], sender_mac[154:107],
   // arrival_port[162:155], zero pad to 168
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata      // status[1:0], entry_slot[6:2], zero pad
);

   cmd_type cmd;
   stat_type stat;
   logic req_fire;
   logic rsp_valid_ff;
   logic [1:0] res_status;
   logic [SLOT_OUT_W-1:0] res_slot;
   logic [1:0] st_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;

   assign csr_ready = 1'b1;
   assign req_fire = req_tvalid && req_tready;

   rtu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_busy (rsp_valid_ff && !rsp_tready),
      .stat     (stat),
      .req_ready(req_tready),
      .cmd      (cmd)
   );

   rtu_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_fire    (csr_valid && csr_ready),
      .csr_own_addr(csr_data),
      .in_kind     (req_tdata[1:0]),
      .in_src      (req_tdata[33:2]),
      .in_dst      (req_tdata[65:34]),
      .in_bid      (req_tdata[97:66]),
      .in_hops     (req_tdata[105:98]),
      .in_force    (req_tdata[106]),
      .in_mac      (req_tdata[154:107]),
      .in_port     (req_tdata[162:155]),
      .stat        (stat),
      .res_status  (res_status),
      .res_slot    (res_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         st_ff <= res_status;
         slot_ff <= res_slot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, slot_ff, st_ff};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !rsp_tvalid || rsp_tready || 1'b1)
      else $error("unreachable");
`endif

endmodule
